/* src/tplsc_pkg.sv */
// shared types and constants for the trail path length and speed core
// no dependencies; imported by the square root unit, the divider and the top level
package tplsc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 4;
  localparam int unsigned LEN_W          = 32;
  localparam int unsigned SEC_W          = 16;
  localparam int unsigned MODE_W         = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TICK  = 2'd2
  } tplsc_mode_e;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } tplsc_unit_sts_t;

endpackage

/* src/trail_path_length_and_speed_core.sv */
// trail path length and speed: top level with sequencer, shared squarer and result register
// depends on tplsc_pkg, tplsc_sqrt and tplsc_div
// timing: set by the 32-step divider and, for a measured segment, the squarer steps
//   (multiply x, multiply y, add) and the coord_bits+frac_bits+1 step square root; the
//   divider is not started when seconds are zero
// throughput: one transaction in flight, the next can be accepted from the cycle after the
//   result register loads; a result held by back-pressure stalls the finish step
// reset: asynchronous active low, clears the trail, length, seconds and output valid
module trail_path_length_and_speed_core #(
  parameter int unsigned COORD_BITS = tplsc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tplsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata from bit 0: pos_x, pos_y, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser: mode
  input  logic [tplsc_pkg::MODE_W-1:0]        s_axis_tuser_i,
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata from bit 0: point_kept, path_length, elapsed_seconds, speed, speed_valid,
  // zero fill
  output logic [87:0]                         m_axis_tdata_o
);
  import tplsc_pkg::*;

  localparam int unsigned SQ0_W  = 2 * COORD_BITS + 1;         // dx^2 + dy^2
  localparam int unsigned SQ_W   = SQ0_W + 2 * FRAC_BITS;      // scaled to fraction bits
  localparam int unsigned RAD_W  = SQ_W + (SQ_W % 2);          // even radicand width
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned OUT_W  = 1 + LEN_W + SEC_W + LEN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD,
    ST_SQRT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q;

  // trail state
  logic [COORD_BITS-1:0] last_x_q;
  logic [COORD_BITS-1:0] last_y_q;
  logic                  has_point_q;
  logic [LEN_W-1:0]      length_q;
  logic [SEC_W-1:0]      seconds_q;

  // per-transaction working registers
  logic                    kept_q;
  logic [COORD_BITS-1:0]   dx_q;
  logic [COORD_BITS-1:0]   dy_q;
  logic [2*COORD_BITS-1:0] mult_q;
  logic [SQ0_W-1:0]        acc_q;
  logic [RAD_W-1:0]        rad_q;
  logic                    sqrt_start_q;
  logic                    div_start_q;
  logic [LEN_W-1:0]        speed_q;

  // result register
  logic              m_valid_q;
  logic [OUT_W-1:0]  out_q;

  // input fields
  tplsc_mode_e           in_mode;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic                  take;
  logic [COORD_BITS-1:0] abs_dx;
  logic [COORD_BITS-1:0] abs_dy;

  // shared squarer and sum
  logic [COORD_BITS-1:0]   mul_op;
  logic [2*COORD_BITS-1:0] product;
  logic [SQ0_W-1:0]        sum_sq;
  logic [RAD_W-1:0]        rad_val;
  logic [LEN_W:0]          len_sum;

  tplsc_unit_sts_t   sqrt_sts;
  tplsc_unit_sts_t   div_sts;
  logic [ROOT_W-1:0] root;
  logic [LEN_W-1:0]  quotient;

  logic s_accept;
  logic out_free;

  assign in_mode = tplsc_mode_e'(s_axis_tuser_i);
  assign in_x    = s_axis_tdata_i[COORD_BITS-1:0];
  assign in_y    = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];

  // a point is taken from an empty (0,0) last point, or when both coordinates move
  assign take   = ((last_x_q == '0) && (last_y_q == '0)) ||
                  ((last_x_q != in_x) && (last_y_q != in_y));
  assign abs_dx = (in_x > last_x_q) ? (in_x - last_x_q) : (last_x_q - in_x);
  assign abs_dy = (in_y > last_y_q) ? (in_y - last_y_q) : (last_y_q - in_y);

  assign mul_op  = (state_q == ST_MUL_X) ? dx_q : dy_q;
  assign product = mul_op * mul_op;
  assign sum_sq  = acc_q + {1'b0, mult_q};
  assign rad_val = {{(RAD_W-SQ0_W){1'b0}}, sum_sq} << (2 * FRAC_BITS);
  assign len_sum = {1'b0, length_q} + {{(LEN_W+1-ROOT_W){1'b0}}, root};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  tplsc_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .rad_i   (rad_q),
    .sts_o   (sqrt_sts),
    .root_o  (root)
  );

  tplsc_div #(
    .DVD_W (LEN_W),
    .DVS_W (SEC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (length_q),
    .divisor_i  (seconds_q),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  // sequencer: update state on accept, measure the segment, then divide for speed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_x_q     <= '0;
      last_y_q     <= '0;
      has_point_q  <= 1'b0;
      length_q     <= '0;
      seconds_q    <= '0;
      kept_q       <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      // one-cycle start pulses for the shared units
      sqrt_start_q <= (state_q == ST_ADD);
      div_start_q  <= (state_q == ST_DIV) && (seconds_q != '0);
      // result register loads when the finish step finds it free
      if ((state_q == ST_FINISH) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            kept_q  <= (in_mode == MODE_ADD) && take;
            // the first point after a clear adds no segment
            state_q <= ((in_mode == MODE_ADD) && take && has_point_q) ? ST_MUL_X : ST_DIV;
            case (in_mode)
              MODE_ADD: begin
                if (take) begin
                  last_x_q    <= in_x;
                  last_y_q    <= in_y;
                  has_point_q <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                last_x_q    <= '0;
                last_y_q    <= '0;
                has_point_q <= 1'b0;
                length_q    <= '0;
                seconds_q   <= '0;
              end
              MODE_TICK: begin
                if (seconds_q != '1) begin
                  seconds_q <= seconds_q + SEC_W'(1);
                end
              end
              // unused mode leaves the state alone
              default: ;
            endcase
          end
        end
        ST_MUL_X: state_q <= ST_MUL_Y;
        ST_MUL_Y: state_q <= ST_ADD;
        ST_ADD: begin
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sqrt_sts.done) begin
            // saturating add of the segment length
            length_q <= len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
            state_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          state_q <= (seconds_q == '0) ? ST_FINISH : ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_sts.done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait until the result register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      dx_q <= abs_dx;
      dy_q <= abs_dy;
    end
    if (state_q == ST_MUL_X) begin
      mult_q <= product;
    end
    if (state_q == ST_MUL_Y) begin
      acc_q  <= {1'b0, mult_q};
      mult_q <= product;
    end
    if (state_q == ST_ADD) begin
      rad_q <= rad_val;
    end
    if ((state_q == ST_DIV) && (seconds_q == '0)) begin
      speed_q <= '0;
    end
    if ((state_q == ST_DIV_WAIT) && div_sts.done) begin
      speed_q <= quotient;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_q <= {(seconds_q != '0), speed_q, seconds_q, length_q, kept_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(88-OUT_W){1'b0}}, out_q};

  // the two units never run at the same time
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_sts.busy && div_sts.busy))
    else $error("square root and divider busy together");

  // an accepted transaction holds off the next one
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // speed is flagged valid only with nonzero seconds
  a_speed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q[OUT_W-1]) |-> (out_q[OUT_W-2-LEN_W -: SEC_W] != '0))
    else $error("speed valid with zero seconds");

  // a square root only starts from the add step of a measured segment
  a_sqrt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start_q |-> ($past(state_q) == ST_ADD) && kept_q)
    else $error("square root started out of sequence");

endmodule

/* src/tplsc_sqrt.sv */
// iterative integer square root, rounded down, one result bit per cycle
// depends on tplsc_pkg for the unit status type
module tplsc_sqrt #(
  parameter int unsigned RAD_W = 34
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [RAD_W-1:0]          rad_i,
  output tplsc_pkg::tplsc_unit_sts_t sts_o,
  output logic [RAD_W/2-1:0]        root_o
);
  import tplsc_pkg::*;

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

/* src/tplsc_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on tplsc_pkg for the unit status type and default widths
module tplsc_div #(
  parameter int unsigned DVD_W = tplsc_pkg::LEN_W,
  parameter int unsigned DVS_W = tplsc_pkg::SEC_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [DVS_W-1:0]           divisor_i,
  output tplsc_pkg::tplsc_unit_sts_t sts_o,
  output logic [DVD_W-1:0]           quotient_o
);
  import tplsc_pkg::*;

  localparam int unsigned REM_W = DVS_W + 1;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [REM_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [REM_W-1:0] rem_sh;
  logic             fits;

  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench for trail_path_length_and_speed_core: directed and random stream traffic
// with random idling on both sides, checked against an in-bench trail predictor
// depends on tplsc_pkg and the core rtl only
module tb;
  import tplsc_pkg::*;

  localparam int unsigned CW           = COORD_BITS_DEF;
  localparam int unsigned FW           = FRAC_BITS_DEF;
  localparam int unsigned IN_W         = ((2*CW+7)/8)*8;
  localparam int unsigned OUT_W        = 88;
  // mode code the core leaves unused, reports state unchanged
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CW-1:0]    CMAX    = '1;
  localparam logic [SEC_W-1:0] SEC_SAT = '1;
  localparam longint unsigned  LEN_MAX64 = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 1130;
  // no idling once this few items are left to send
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned REPORT_MAX   = 10;
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

  // result tdata layout, from bit 0 up
  localparam int unsigned KEPT_LSB = 0;
  localparam int unsigned LEN_LSB  = 1;
  localparam int unsigned SEC_LSB  = LEN_LSB + LEN_W;
  localparam int unsigned SPD_LSB  = SEC_LSB + SEC_W;
  localparam int unsigned SOK_LSB  = SPD_LSB + LEN_W;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
  } trail_item_t;

  typedef struct packed {
    logic             kept;
    logic [LEN_W-1:0] length;
    logic [SEC_W-1:0] seconds;
    logic [LEN_W-1:0] speed;
    logic             speed_ok;
  } trail_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // fields from bit 0: pos_x, pos_y, zero fill
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  // fields: mode
  logic [MODE_W-1:0] s_axis_tuser_i = MODE_ADD;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // fields from bit 0: point_kept, path_length, elapsed_seconds, speed, speed_valid, zero fill
  logic [OUT_W-1:0] m_axis_tdata_o;

  trail_path_length_and_speed_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // stimulus waiting to go out, and predicted results waiting to come back
  trail_item_t   pending_items[$];
  trail_sample_t expected_samples[$];
  int unsigned   mismatch_cnt = 0;

  // predictor copy of the trail state
  logic [CW-1:0]    trl_x = '0;
  logic [CW-1:0]    trl_y = '0;
  logic             trl_has = 1'b0;
  logic [LEN_W-1:0] trl_len = '0;
  logic [SEC_W-1:0] trl_secs = '0;

  // driver and monitor working variables
  logic          in_taken = 1'b0;
  logic          calm = 1'b0;
  logic          offer = 1'b0;
  int unsigned   in_gap = 0;
  int unsigned   out_gap = 0;
  trail_item_t   drv_item = '0;
  trail_item_t   seen_item;
  trail_sample_t got_sample;
  trail_sample_t want_sample;

  // bitwise integer square root, rounded down
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    rem  = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // apply one accepted transaction to the trail state and give the result it should produce
  task automatic advance_trail(input trail_item_t it, output trail_sample_t s);
    logic            take;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned sum;
    s = '0;
    case (it.mode)
      MODE_ADD: begin
        // a stored (0,0) lets any point in, otherwise both coordinates must move
        if (trl_x == '0 && trl_y == '0) take = 1'b1;
        else take = (trl_x != it.x) && (trl_y != it.y);
        if (take) begin
          if (trl_has) begin
            dx  = (trl_x > it.x) ? 64'(trl_x - it.x) : 64'(it.x - trl_x);
            dy  = (trl_y > it.y) ? 64'(trl_y - it.y) : 64'(it.y - trl_y);
            sum = 64'(trl_len) + floor_sqrt((dx * dx + dy * dy) << (2 * FW));
            trl_len = (sum > LEN_MAX64) ? '1 : sum[LEN_W-1:0];
          end
          trl_x   = it.x;
          trl_y   = it.y;
          trl_has = 1'b1;
          s.kept  = 1'b1;
        end
      end
      MODE_CLEAR: begin
        trl_x    = '0;
        trl_y    = '0;
        trl_has  = 1'b0;
        trl_len  = '0;
        trl_secs = '0;
      end
      MODE_TICK: begin
        if (trl_secs != SEC_SAT) trl_secs = trl_secs + 1'b1;
      end
      default: ;
    endcase
    s.length  = trl_len;
    s.seconds = trl_secs;
    if (trl_secs != '0) begin
      s.speed    = trl_len / trl_secs;
      s.speed_ok = 1'b1;
    end
  endtask

  task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [CW-1:0] x,
                            input logic [CW-1:0] y);
    trail_item_t it;
    it.mode = mode;
    it.x    = x;
    it.y    = y;
    pending_items = {pending_items, it};
  endtask

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the core hangs
  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

  // driver for both sides: inputs change at the falling edge only
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      m_axis_tready_i <= 1'b0;
    end else begin
      calm = pending_items.size() < QUIET_TAIL;
      // input side: only move on once the current transaction has gone through
      if (!s_axis_tvalid_i || in_taken) begin
        offer = 1'b0;
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            // start an idle burst, counting this one
            in_gap = $urandom_range(0, 3);
          end else begin
            drv_item = pending_items.pop_front();
            offer    = 1'b1;
          end
        end
        s_axis_tvalid_i <= offer;
        s_axis_tuser_i  <= drv_item.mode;
        s_axis_tdata_i  <= IN_W'({drv_item.y, drv_item.x});
      end
      // result side: random back-pressure bursts, none in the tail
      if (out_gap != 0) begin
        out_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      // predict from what the core actually saw on the bus
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        seen_item.mode = s_axis_tuser_i;
        seen_item.x    = s_axis_tdata_i[CW-1:0];
        seen_item.y    = s_axis_tdata_i[2*CW-1:CW];
        advance_trail(seen_item, want_sample);
        expected_samples = {expected_samples, want_sample};
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_sample.kept     = m_axis_tdata_o[KEPT_LSB];
        got_sample.length   = m_axis_tdata_o[LEN_LSB +: LEN_W];
        got_sample.seconds  = m_axis_tdata_o[SEC_LSB +: SEC_W];
        got_sample.speed    = m_axis_tdata_o[SPD_LSB +: LEN_W];
        got_sample.speed_ok = m_axis_tdata_o[SOK_LSB];
        if (expected_samples.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("unexpected result at %0t: kept=%0d len=%0d secs=%0d speed=%0d ok=%0d",
                     $realtime, got_sample.kept, got_sample.length, got_sample.seconds,
                     got_sample.speed, got_sample.speed_ok);
        end else begin
          want_sample = expected_samples.pop_front();
          if (got_sample !== want_sample) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("mismatch at %0t: expected kept=%0d len=%0d secs=%0d speed=%0d ok=%0d",
                       $realtime, want_sample.kept, want_sample.length, want_sample.seconds,
                       want_sample.speed, want_sample.speed_ok);
              $display("  got kept=%0d len=%0d secs=%0d speed=%0d ok=%0d",
                       got_sample.kept, got_sample.length, got_sample.seconds,
                       got_sample.speed, got_sample.speed_ok);
            end
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stim
    int unsigned sent;
    int unsigned pick;
    logic [MODE_W-1:0] mode;
    logic [CW-1:0] gx;
    logic [CW-1:0] gy;
    logic [CW-1:0] last_gx;
    logic [CW-1:0] last_gy;

    // directed part
    queue_item(MODE_ADD, '0, '0);          // first point at the origin, trail still length 0
    queue_item(MODE_ADD, CMAX, CMAX);      // measured from the origin, longest diagonal
    queue_item(MODE_ADD, CMAX, 12'd100);   // same x, rejected
    queue_item(MODE_ADD, 12'd100, CMAX);   // same y, rejected
    queue_item(MODE_ADD, '0, '0);          // back to the origin, kept
    queue_item(MODE_ADD, '0, '0);          // origin stored, so taken again with no length
    queue_item(MODE_ADD, CMAX, '0);        // straight run along x
    queue_item(MODE_UNUSED, 12'd123, 12'd456);
    queue_item(MODE_TICK, CMAX, CMAX);     // first second, speed becomes valid
    queue_item(MODE_TICK, '0, '0);
    queue_item(MODE_ADD, 12'd1, 12'd1);
    queue_item(MODE_ADD, 12'd2, 12'd3);
    queue_item(MODE_CLEAR, CMAX, CMAX);
    queue_item(MODE_ADD, 12'd5, 12'd7);    // single point after clear, no length
    queue_item(MODE_TICK, '0, '0);
    queue_item(MODE_ADD, CMAX, CMAX);
    queue_item(MODE_UNUSED, CMAX, CMAX);
    queue_item(MODE_TICK, 12'd1, 12'd2);
    queue_item(MODE_TICK, 12'd3, 12'd4);
    queue_item(MODE_TICK, 12'd5, 12'd6);
    queue_item(MODE_CLEAR, '0, '0);
    queue_item(MODE_TICK, '0, '0);         // seconds but no trail, speed 0 and valid
    queue_item(MODE_ADD, '0, CMAX);
    queue_item(MODE_ADD, CMAX, '0);
    queue_item(MODE_CLEAR, '0, '0);

    // random part: mostly well-formed trails with ticks, rare clears and noise
    sent    = 0;
    last_gx = '0;
    last_gy = '0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      gx   = CW'($urandom());
      gy   = CW'($urandom());
      if (pick < 70) begin
        mode = MODE_ADD;
        pick = $urandom_range(0, 99);
        if (pick < 8) gx = last_gx;               // blocked by equal x
        else if (pick < 16) gy = last_gy;         // blocked by equal y
        else if (pick < 19) begin
          gx = '0;
          gy = '0;
        end else if (pick < 24) begin
          gx = $urandom_range(0, 1) ? CMAX : '0;
          gy = $urandom_range(0, 1) ? CMAX : '0;
        end
        last_gx = gx;
        last_gy = gy;
      end else if (pick < 90) begin
        mode = MODE_TICK;
      end else if (pick < 92) begin
        mode = MODE_CLEAR;
      end else begin
        mode = MODE_UNUSED;
      end
      queue_item(mode, gx, gy);
      sent++;
    end

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for every transaction to go in and every result to come out
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid_i || expected_samples.size() != 0);
    // let any stray output show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
